/* hw/rtl/rss_pkg.sv */
// shared types and constants of the running sample statistics block
package rss_pkg;

    localparam int COUNT_BITS  = 24;
    localparam int SAMPLE_BITS = 16;
    localparam int VAR_BITS    = 32;

    localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_BITS    = 2 * SAMPLE_BITS;
    localparam int SQSUM_BITS = SQ_BITS + COUNT_BITS;
    localparam int NUM_BITS   = 2 * SUM_BITS;
    localparam int PAIR_BITS  = 2 * COUNT_BITS;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic                          command;
        logic signed [SAMPLE_BITS-1:0] sample;
    } rss_in_t;

    typedef struct packed {
        logic        [COUNT_BITS-1:0]  count;
        logic signed [SAMPLE_BITS-1:0] mean_value;
        logic        [VAR_BITS-1:0]    variance;
        logic signed [SAMPLE_BITS-1:0] minimum;
        logic signed [SAMPLE_BITS-1:0] maximum;
        logic signed [SAMPLE_BITS-1:0] last_value;
        logic                          count_full;
    } rss_out_t;

endpackage

/* hw/rtl/running_sample_statistics.sv */
// running count, mean, variance, minimum and maximum of signed samples
//
// Each transaction either adds one sample or clears all statistics and returns one result
// with the statistics after the update; with a saturated count the sample is dropped and
// count_full is set. The block takes one transaction at a time: s_ready is high only while
// the sequencer is idle, and a finished result waits in an output register, so the next
// transaction can be taken while that result is still pending. All heavy arithmetic but
// the sample square, which has its own multiplier, runs through one shared add/subtract
// unit: the mean is a restoring division over SAMPLE_BITS steps, n*sumsq and sum^2 are
// shift-add multiplications over COUNT_BITS and SAMPLE_BITS+COUNT_BITS steps, and the
// variance is a restoring division over 32 steps. The multiplications and the variance
// division are skipped below two samples, the mean division too when empty, and the
// variance division on saturation; the done state holds while a result waits on m_ready.
module running_sample_statistics
    import rss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  rss_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output rss_out_t m_data
);

    localparam int STEP_MAX = (SUM_BITS > VAR_BITS) ? SUM_BITS : VAR_BITS;
    localparam int STEP_W   = $clog2(STEP_MAX + 1);
    localparam int ALU_W    = NUM_BITS + 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ   = 4'd1;
    localparam logic [3:0] ST_UPD  = 4'd2;
    localparam logic [3:0] ST_MSET = 4'd3;
    localparam logic [3:0] ST_MDIV = 4'd4;
    localparam logic [3:0] ST_MUL1 = 4'd5;
    localparam logic [3:0] ST_MUL2 = 4'd6;
    localparam logic [3:0] ST_VCHK = 4'd7;
    localparam logic [3:0] ST_VDIV = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0] state_reg, state_next;

    logic                          cmd_reg, cmd_next;
    logic signed [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [SQ_BITS-1:0]            sq_reg, sq_next;

    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic signed [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SQSUM_BITS-1:0]         sqsum_reg, sqsum_next;
    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] last_reg, last_next;
    logic [PAIR_BITS-1:0]          pair_reg, pair_next;
    logic                          full_reg, full_next;

    logic                          sneg_reg, sneg_next;
    logic [SUM_BITS-1:0]           smag_reg, smag_next;
    logic [NUM_BITS-1:0]           acc_reg, acc_next;
    logic [NUM_BITS-1:0]           mcand_reg, mcand_next;
    logic [SUM_BITS-1:0]           mplier_reg, mplier_next;
    logic [NUM_BITS-1:0]           rem_reg, rem_next;
    logic [PAIR_BITS-1:0]          dvs_reg, dvs_next;
    logic [VAR_BITS-1:0]           qsh_reg, qsh_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic signed [SAMPLE_BITS-1:0] mean_reg, mean_next;
    logic [VAR_BITS-1:0]           var_reg, var_next;

    rss_out_t out_reg, out_next;
    logic     m_valid_reg, m_valid_next;

    // shared add/subtract unit
    logic [ALU_W-1:0] alu_a, alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_res;
    logic             alu_borrow;

    logic [SAMPLE_BITS-1:0]       smp_mag;
    logic [SUM_BITS-1:0]          sum_mag;
    logic [NUM_BITS+VAR_BITS-1:0] acc_wide;
    logic [NUM_BITS-1:0]          acc_hi;
    logic [VAR_BITS-1:0]          acc_lo;
    logic [NUM_BITS-1:0]          rem_step;
    logic [VAR_BITS-1:0]          qsh_step;
    logic [SAMPLE_BITS-1:0]       mean_mag;
    logic                         step_last;

    assign smp_mag  = smp_reg[SAMPLE_BITS-1] ? $unsigned(-smp_reg) : $unsigned(smp_reg);
    assign sum_mag  = sum_reg[SUM_BITS-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);
    assign acc_wide = {{VAR_BITS{1'b0}}, acc_reg};
    assign acc_hi   = acc_wide[NUM_BITS+VAR_BITS-1:VAR_BITS];
    assign acc_lo   = acc_wide[VAR_BITS-1:0];
    assign step_last = (step_reg == STEP_W'(1));

    always_comb begin
        alu_a   = {1'b0, acc_reg};
        alu_b   = {1'b0, mcand_reg};
        alu_sub = 1'b0;
        unique case (state_reg) inside
            ST_MUL2: begin
                alu_sub = 1'b1;
            end
            ST_MDIV, ST_VDIV: begin
                alu_a   = {rem_reg, qsh_reg[VAR_BITS-1]};
                alu_b   = ALU_W'(dvs_reg);
                alu_sub = 1'b1;
            end
            ST_VCHK: begin
                alu_a   = ALU_W'(acc_hi);
                alu_b   = ALU_W'(pair_reg);
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
        alu_res = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
    end

    assign alu_borrow = alu_res[ALU_W];

    // one restoring division step
    assign rem_step = alu_borrow ? alu_a[NUM_BITS-1:0] : alu_res[NUM_BITS-1:0];
    assign qsh_step = {qsh_reg[VAR_BITS-2:0], ~alu_borrow};
    assign mean_mag = qsh_step[SAMPLE_BITS-1:0];

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        smp_next     = smp_reg;
        sq_next      = sq_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        sqsum_next   = sqsum_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        last_next    = last_reg;
        pair_next    = pair_reg;
        full_next    = full_reg;
        sneg_next    = sneg_reg;
        smag_next    = smag_reg;
        acc_next     = acc_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        qsh_next     = qsh_reg;
        step_next    = step_reg;
        mean_next    = mean_reg;
        var_next     = var_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next   = s_data.command;
                    smp_next   = s_data.sample;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                sq_next    = smp_mag * smp_mag;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                full_next = 1'b0;
                if (cmd_reg == CMD_CLEAR) begin
                    count_next = '0;
                    sum_next   = '0;
                    sqsum_next = '0;
                    min_next   = SAMPLE_MAX;
                    max_next   = SAMPLE_MIN;
                    last_next  = '0;
                    pair_next  = '0;
                end else if (count_reg == '1) begin
                    full_next = 1'b1;
                end else begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + SUM_BITS'(smp_reg);
                    sqsum_next = sqsum_reg + SQSUM_BITS'(sq_reg);
                    // n(n-1) grows by 2*n_old per added sample
                    pair_next  = pair_reg + PAIR_BITS'({count_reg, 1'b0});
                    last_next  = smp_reg;
                    if (smp_reg < min_reg) begin
                        min_next = smp_reg;
                    end
                    if (smp_reg > max_reg) begin
                        max_next = smp_reg;
                    end
                end
                state_next = ST_MSET;
            end
            ST_MSET: begin
                sneg_next = sum_reg[SUM_BITS-1];
                smag_next = sum_mag;
                if (count_reg == '0) begin
                    mean_next  = '0;
                    var_next   = '0;
                    state_next = ST_DONE;
                end else begin
                    // quotient fits in SAMPLE_BITS, so start with the upper part in the remainder
                    rem_next   = NUM_BITS'(sum_mag >> SAMPLE_BITS);
                    qsh_next   = VAR_BITS'(sum_mag[SAMPLE_BITS-1:0]) << (VAR_BITS - SAMPLE_BITS);
                    dvs_next   = PAIR_BITS'(count_reg);
                    step_next  = STEP_W'(SAMPLE_BITS);
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV: begin
                rem_next  = rem_step;
                qsh_next  = qsh_step;
                step_next = step_reg - 1'b1;
                if (step_last) begin
                    mean_next = sneg_reg ? $signed(-mean_mag) : $signed(mean_mag);
                    if (count_reg < COUNT_BITS'(2)) begin
                        var_next   = '0;
                        state_next = ST_DONE;
                    end else begin
                        acc_next    = '0;
                        mcand_next  = NUM_BITS'(sqsum_reg);
                        mplier_next = SUM_BITS'(count_reg);
                        step_next   = STEP_W'(COUNT_BITS);
                        state_next  = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                if (mplier_reg[0]) begin
                    acc_next = alu_res[NUM_BITS-1:0];
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 1'b1;
                if (step_last) begin
                    mcand_next  = NUM_BITS'(smag_reg);
                    mplier_next = smag_reg;
                    step_next   = STEP_W'(SUM_BITS);
                    state_next  = ST_MUL2;
                end
            end
            ST_MUL2: begin
                // subtract sum^2; partial results may wrap but the final value is not negative
                if (mplier_reg[0]) begin
                    acc_next = alu_res[NUM_BITS-1:0];
                end
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                step_next   = step_reg - 1'b1;
                if (step_last) begin
                    state_next = ST_VCHK;
                end
            end
            ST_VCHK: begin
                if (!alu_borrow) begin
                    // quotient would not fit in VAR_BITS
                    var_next   = '1;
                    state_next = ST_DONE;
                end else begin
                    rem_next   = acc_hi;
                    qsh_next   = acc_lo;
                    dvs_next   = pair_reg;
                    step_next  = STEP_W'(VAR_BITS);
                    state_next = ST_VDIV;
                end
            end
            ST_VDIV: begin
                rem_next  = rem_step;
                qsh_next  = qsh_step;
                step_next = step_reg - 1'b1;
                if (step_last) begin
                    var_next   = qsh_step;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.count      = count_reg;
                    out_next.mean_value = mean_reg;
                    out_next.variance   = var_reg;
                    out_next.minimum    = min_reg;
                    out_next.maximum    = max_reg;
                    out_next.last_value = last_reg;
                    out_next.count_full = full_reg;
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= '0;
            sqsum_reg   <= '0;
            min_reg     <= SAMPLE_MAX;
            max_reg     <= SAMPLE_MIN;
            last_reg    <= '0;
            pair_reg    <= '0;
            full_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            sqsum_reg   <= sqsum_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            last_reg    <= last_next;
            pair_reg    <= pair_next;
            full_reg    <= full_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        smp_reg    <= smp_next;
        sq_reg     <= sq_next;
        sneg_reg   <= sneg_next;
        smag_reg   <= smag_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        qsh_reg    <= qsh_next;
        step_reg   <= step_next;
        mean_reg   <= mean_next;
        var_reg    <= var_next;
        out_reg    <= out_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

endmodule

/* hw/rtl/rss_checker.sv */
// port-level checks of the running sample statistics block, bound to its top level
module rss_checker
    import rss_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input rss_in_t  s_data,
    input logic     m_valid,
    input logic     m_ready,
    input rss_out_t m_data
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // one transaction at a time: busy right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while busy");

    // a dropped sample is reported only with a saturated count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.count_full |-> (&m_data.count))
        else $error("count_full without saturated count");

    // variance is zero below two samples
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.count < COUNT_BITS'(2)) |-> (m_data.variance == '0))
        else $error("nonzero variance with fewer than two samples");

    // empty statistics report their reset values
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.count == '0) |->
            (m_data.mean_value == '0) && (m_data.minimum == SAMPLE_MAX) &&
            (m_data.maximum == SAMPLE_MIN) && (m_data.last_value == '0))
        else $error("empty statistics not at reset values");

endmodule

bind running_sample_statistics rss_checker u_rss_checker (.*);
